### hdl/obs_pkg.sv
// ----------------------------------------------------------------------------
// obs_pkg
// Shared constants for the ordered byte set: request codes, field widths and
// the default capacity.
// ----------------------------------------------------------------------------
package obs_pkg;

   localparam int SET_CAPACITY_DEF = 32;

   localparam int TYPE_W  = 2;
   localparam int ITEM_W  = 8;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 6;

   localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;

endpackage

### hdl/obs_if.sv
// ----------------------------------------------------------------------------
// obs_req_if / obs_rsp_if
// Valid/ready channels of the ordered byte set: requests in, results out.
// ----------------------------------------------------------------------------
interface obs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] item;

   modport source (output valid, output req_type, output item, input ready);
   modport sink   (input valid, input req_type, input item, output ready);
endinterface

interface obs_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [4:0] position;
   logic       overflow;
   logic [5:0] count;

   modport source (output valid, output found, output position, output overflow,
                   output count, input ready);
   modport sink   (input valid, input found, input position, input overflow,
                   input count, output ready);
endinterface

### hdl/obs_ram.sv
// ----------------------------------------------------------------------------
// obs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module obs_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/ordered_byte_set.sv
// Every request scans the stored entries in order and stops early on a hit;
// remove then shifts the entries after the hit down by one to close the gap.
// Throughput: one request at a time; the entry RAM read port scans one stored
// entry per cycle.
// Reset (synchronous, active high) empties the set; entry RAM is not cleared.
// ----------------------------------------------------------------------------
// ordered_byte_set
// Bounded set of distinct bytes kept in insertion order, with insert, remove
// and lookup requests. One sequencer scans and shifts the entry RAM.
// ----------------------------------------------------------------------------
module ordered_byte_set #(
   parameter int SET_CAPACITY = obs_pkg::SET_CAPACITY_DEF
) (
   input  logic      clock,
   input  logic      reset,
   obs_req_if.sink   req_port,
   obs_rsp_if.source rsp_port
);

   import obs_pkg::*;

   localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
   localparam int CW = $clog2(SET_CAPACITY + 1);
   localparam logic [CW-1:0] CAP = CW'(SET_CAPACITY);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     occ_ff, occ_in;
   logic [CW-1:0]     scan_ff, scan_in;     // next address to read
   logic              cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]     cmp_idx_ff, cmp_idx_in; // address of data now on rd_data
   logic              found_ff, found_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic              ovf_ff, ovf_in;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [ITEM_W-1:0] item_ff, item_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [ITEM_W-1:0] wr_data, rd_data;
   logic              hit, more;
   logic              load_rsp;

   obs_ram #(
      .WIDTH (ITEM_W),
      .DEPTH (SET_CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hit  = cmp_valid_ff && (rd_data == item_ff);
   assign more = scan_ff < occ_ff;
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_port.ready);

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      scan_in      = scan_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      type_in      = type_ff;
      item_in      = item_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(occ_ff);
      wr_data      = item_ff;
      rd_en        = 1'b0;
      rd_addr      = AW'(scan_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               type_in  = req_port.req_type;
               item_in  = req_port.item;
               scan_in  = '0;
               found_in = 1'b0;
               pos_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!hit && more) begin
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = AW'(scan_ff);
               scan_in      = scan_ff + 1'b1;
            end else begin
               found_in = hit;
               pos_in   = hit ? cmp_idx_ff : '0;
               state_in = ST_DONE;
               case (type_ff)
                  REQ_INSERT: begin
                     if (occ_ff >= CAP) begin
                        ovf_in = 1'b1;
                     end else if (!hit) begin
                        wr_en  = 1'b1;
                        occ_in = occ_ff + 1'b1;
                     end
                  end
                  REQ_REMOVE: begin
                     if (hit) begin
                        scan_in  = CW'(cmp_idx_ff) + 1'b1;
                        state_in = ST_SHIFT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // read entry k+1 while writing the entry read last cycle (k) to k-1
            if (cmp_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = cmp_idx_ff - 1'b1;
               wr_data = rd_data;
            end
            if (more) begin
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = AW'(scan_ff);
               scan_in      = scan_ff + 1'b1;
            end else begin
               occ_in   = occ_ff - 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_count_in = rsp_count_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff;
         rsp_pos_in   = POS_W'(pos_ff);
         rsp_ovf_in   = ovf_ff;
         rsp_count_in = COUNT_W'(occ_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      cmp_idx_ff   <= cmp_idx_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      ovf_ff       <= ovf_in;
      type_ff      <= type_in;
      item_ff      <= item_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_port.ready    = (state_ff == ST_IDLE);
   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.found    = rsp_found_ff;
   assign rsp_port.position = rsp_pos_ff;
   assign rsp_port.overflow = rsp_ovf_ff;
   assign rsp_port.count    = rsp_count_ff;

endmodule

### verif/ordered_byte_set_tb.sv
// ----------------------------------------------------------------------------
// ordered_byte_set_tb
// Self-checking bench for the ordered byte set. A queue of requests (a short
// directed list, then random fill/drain/mixed phases over small value pools)
// feeds a valid/ready driver; a shadow copy of the set predicts found,
// position, overflow and count for every accepted request, and a monitor
// checks the results in order under random backpressure.
// ----------------------------------------------------------------------------
module ordered_byte_set_tb;
   import obs_pkg::*;

   localparam int SET_CAPACITY = SET_CAPACITY_DEF;
   localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;   // behaves as lookup

   localparam int ITEM_TARGET = 1800;
   localparam int CALM_TAIL   = 150;    // last requests go without idling
   localparam int SETTLE_WAIT = 100;    // extra wait after the last result, before the verdict
   localparam int STALL_LIMIT = 2000;

   typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_type;

   typedef struct packed {
      logic               found;
      logic [POS_W-1:0]   position;
      logic               overflow;
      logic [COUNT_W-1:0] count;
   } set_result_type;

   typedef struct {
      bit                hold;     // wait until all results are back
      logic [TYPE_W-1:0] kind;
      logic [ITEM_W-1:0] value;
   } backlog_entry_type;

   logic clock;
   logic reset;

   obs_req_if req_ch ();
   obs_rsp_if rsp_ch ();

   ordered_byte_set #(.SET_CAPACITY(SET_CAPACITY)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   backlog_entry_type request_backlog [$];
   set_result_type    awaited_results [$];

   // shadow of the set contents
   logic [ITEM_W-1:0] members [SET_CAPACITY];
   int                fill_level;

   int error_count;
   int send_gap;
   int hold_cnt;
   int quiet_cycles;
   bit calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic set_result_type track_set_request(logic [TYPE_W-1:0] kind,
                                                        logic [ITEM_W-1:0] value);
      set_result_type r;
      int hit;
      hit = -1;
      for (int k = 0; k < fill_level; k++)
         if (hit < 0 && members[k] == value) hit = k;
      r = '0;
      if (kind == REQ_INSERT) begin
         // a full set refuses every insert, member or not
         if (fill_level >= SET_CAPACITY) r.overflow = 1'b1;
         else if (hit < 0) begin
            members[fill_level] = value;
            fill_level++;
         end
      end else if (kind == REQ_REMOVE && hit >= 0) begin
         for (int k = hit; k + 1 < fill_level; k++) members[k] = members[k + 1];
         fill_level--;
      end
      r.found    = (hit >= 0);
      r.position = (hit >= 0) ? hit[POS_W-1:0] : '0;
      r.count    = fill_level[COUNT_W-1:0];
      return r;
   endfunction

   task automatic queue_request(logic [TYPE_W-1:0] kind, logic [ITEM_W-1:0] value);
      backlog_entry_type e;
      e.hold  = 1'b0;
      e.kind  = kind;
      e.value = value;
      request_backlog.push_back(e);
   endtask

   task automatic queue_drain_pause();
      backlog_entry_type e;
      e.hold  = 1'b1;
      e.kind  = REQ_LOOKUP;
      e.value = '0;
      request_backlog.push_back(e);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      logic              nxt_valid;
      backlog_entry_type head;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         calm <= (request_backlog.size() < CALM_TAIL);
         nxt_valid = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            awaited_results.push_back(track_set_request(req_ch.req_type, req_ch.item));
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (send_gap > 0) send_gap--;
            else if (request_backlog.size() > 0) begin
               head = request_backlog[0];
               if (head.hold) begin
                  if (awaited_results.size() == 0 && !req_ch.valid)
                     void'(request_backlog.pop_front());
               end else if (!calm && $urandom_range(0, 5) == 0) begin
                  // stay idle this cycle and while send_gap counts down
                  send_gap = $urandom_range(0, 7);
               end else begin
                  void'(request_backlog.pop_front());
                  req_ch.req_type <= head.kind;
                  req_ch.item     <= head.value;
                  nxt_valid = 1'b1;
               end
            end
         end
         req_ch.valid <= nxt_valid;
      end
   end

   // monitor
   always @(posedge clock) begin
      set_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_cnt = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result found=%0d position=%0d overflow=%0d count=%0d",
                        $time, rsp_ch.found, rsp_ch.position, rsp_ch.overflow, rsp_ch.count);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("found",    int'(want.found),    int'(rsp_ch.found));
               check_field("position", int'(want.position), int'(rsp_ch.position));
               check_field("overflow", int'(want.overflow), int'(rsp_ch.overflow));
               check_field("count",    int'(want.count),    int'(rsp_ch.count));
            end
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            hold_cnt = $urandom_range(0, 7);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog: no request or result moving for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("ordered_byte_set_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      phase_type         phase;
      int                span;
      int                pool_base;
      int                pool_size;
      int                ins_pct;
      int                rem_pct;
      int                roll;
      int                episode;
      logic [ITEM_W-1:0] v;

      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_LOOKUP;
      req_ch.item     = '0;
      rsp_ch.ready    = 1'b0;
      error_count     = 0;
      fill_level      = 0;
      quiet_cycles    = 0;
      calm            = 1'b0;

      // directed: empty set, edge bytes, duplicate insert, shifts, unused code
      queue_request(REQ_LOOKUP, 8'h00);
      queue_request(REQ_REMOVE, 8'hFF);
      queue_request(REQ_INSERT, 8'h00);
      queue_request(REQ_INSERT, 8'hFF);
      queue_request(REQ_INSERT, 8'h80);
      queue_request(REQ_INSERT, 8'h01);
      queue_request(REQ_INSERT, 8'hFF);
      queue_request(REQ_LOOKUP, 8'h01);
      queue_request(REQ_LOOKUP, 8'h7F);
      queue_request(REQ_UNUSED, 8'h80);
      queue_request(REQ_REMOVE, 8'hFF);
      queue_request(REQ_LOOKUP, 8'h01);
      queue_request(REQ_REMOVE, 8'h00);
      queue_request(REQ_REMOVE, 8'h00);
      queue_request(REQ_REMOVE, 8'h01);
      queue_request(REQ_INSERT, 8'hAA);
      queue_request(REQ_UNUSED, 8'h55);
      queue_drain_pause();

      // random phases over a small value pool so hits, full sets and
      // overflow (pool wider than capacity) come up often
      episode = 0;
      while (request_backlog.size() < ITEM_TARGET) begin
         phase     = (episode == 0) ? PHASE_FILL : phase_type'($urandom_range(0, 2));
         span      = $urandom_range(40, 140);
         pool_size = (episode == 0) ? 64 : $urandom_range(4, 48);
         pool_base = $urandom_range(0, 255);
         case (phase)
            PHASE_FILL: begin
               ins_pct = 70;
               rem_pct = 15;
            end
            PHASE_DRAIN: begin
               ins_pct = 15;
               rem_pct = 70;
            end
            default: begin
               ins_pct = 35;
               rem_pct = 35;
            end
         endcase
         for (int n = 0; n < span; n++) begin
            if ($urandom_range(0, 9) == 0) v = ITEM_W'($urandom_range(0, 255));
            else v = ITEM_W'((pool_base + $urandom_range(0, pool_size - 1)) % 256);
            roll = $urandom_range(0, 99);
            if (roll < ins_pct) queue_request(REQ_INSERT, v);
            else if (roll < ins_pct + rem_pct) queue_request(REQ_REMOVE, v);
            else if ($urandom_range(0, 4) == 0) queue_request(REQ_UNUSED, v);
            else queue_request(REQ_LOOKUP, v);
         end
         if ($urandom_range(0, 3) == 0) queue_drain_pause();
         episode++;
      end

      @(negedge reset);
      while (request_backlog.size() > 0 || req_ch.valid || awaited_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("ordered_byte_set_tb: clean");
      end else begin
         $display("ordered_byte_set_tb: errors");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/obs_pkg.sv
hdl/obs_if.sv
hdl/obs_ram.sv
hdl/ordered_byte_set.sv
verif/ordered_byte_set_tb.sv
